FILE: hdl/barycentric_z_interpolate_top_assert.svh
// Assertion macros for the barycentric height block.
`ifndef BARYCENTRIC_Z_INTERPOLATE_TOP_ASSERT_SVH
`define BARYCENTRIC_Z_INTERPOLATE_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define BZI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define BZI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/bzi_pkg.sv
package bzi_pkg;

	// Coordinate word width (signed fixed point)
	localparam int COORD_WIDTH = 32;
	// Widest multiplier operand chunk
	localparam int MUL_MAX = 32;
	// Latency of the chunked multiplier
	localparam int MUL_LAT = 2;

	// Exact intermediate widths
	localparam int DIFF_W = COORD_WIDTH + 1;     // coordinate differences
	localparam int PROD_W = 2 * DIFF_W;          // difference products
	localparam int WGT_W  = PROD_W + 1;          // det, w1, w2
	localparam int W3_W   = WGT_W + 2;           // w3 = det - w1 - w2
	localparam int TERM_W = W3_W + COORD_WIDTH;  // weight times height
	localparam int NUM_W  = TERM_W + 2;          // sum of three terms
	localparam int REM_W  = WGT_W + COORD_WIDTH; // divider remainder

	localparam logic signed [COORD_WIDTH-1:0] H_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] H_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] v1_x;
		logic signed [COORD_WIDTH-1:0] v1_y;
		logic signed [COORD_WIDTH-1:0] v1_z;
		logic signed [COORD_WIDTH-1:0] v2_x;
		logic signed [COORD_WIDTH-1:0] v2_y;
		logic signed [COORD_WIDTH-1:0] v2_z;
		logic signed [COORD_WIDTH-1:0] v3_x;
		logic signed [COORD_WIDTH-1:0] v3_y;
		logic signed [COORD_WIDTH-1:0] v3_z;
		logic signed [COORD_WIDTH-1:0] query_x;
		logic signed [COORD_WIDTH-1:0] query_y;
	} bzi_in_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] height;
		logic                          degenerate;
		logic                          saturated;
	} bzi_out_t;

	// Control travelling along the divide chain
	typedef struct packed {
		logic vld;  // word present in this cell
		logic neg;  // quotient sign
		logic deg;  // zero determinant
		logic ovf;  // quotient magnitude beyond the coordinate width
	} bzi_div_ctl_t;

endpackage

FILE: hdl/bzi_mul.sv
// Signed multiplier split into chunks of at most MUL_MAX bits per operand.
// Stage 1 registers the partial products, stage 2 registers their sum.
module bzi_mul #(
	parameter int AW = 33,
	parameter int BW = 33
) (
	input  logic                 clk,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0] p
);
	import bzi_pkg::*;

	localparam int NA = (AW + MUL_MAX - 1) / MUL_MAX;
	localparam int CA = (AW + NA - 1) / NA;
	localparam int NB = (BW + MUL_MAX - 1) / MUL_MAX;
	localparam int CB = (BW + NB - 1) / NB;
	localparam int PW = AW + BW;
	localparam int PPW = CA + CB + 2;

	logic signed [NA*CA-1:0] a_ext;
	logic signed [NB*CB-1:0] b_ext;
	logic signed [CA:0]      a_ch [NA];
	logic signed [CB:0]      b_ch [NB];
	logic signed [PPW-1:0]   pp_s1 [NA][NB];
	logic signed [PW-1:0]    sum;
	logic signed [PW-1:0]    p_s2;

	assign a_ext = (NA*CA)'(a);
	assign b_ext = (NB*CB)'(b);

	// Top chunk keeps the sign, lower chunks are unsigned
	for (genvar i = 0; i < NA; i++) begin : g_a
		if (i == NA - 1) begin : g_top
			assign a_ch[i] = {a_ext[i*CA+CA-1], a_ext[i*CA +: CA]};
		end else begin : g_low
			assign a_ch[i] = {1'b0, a_ext[i*CA +: CA]};
		end
	end

	for (genvar j = 0; j < NB; j++) begin : g_b
		if (j == NB - 1) begin : g_top
			assign b_ch[j] = {b_ext[j*CB+CB-1], b_ext[j*CB +: CB]};
		end else begin : g_low
			assign b_ch[j] = {1'b0, b_ext[j*CB +: CB]};
		end
	end

	// Partial products
	always_ff @(posedge clk) begin
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				pp_s1[i][j] <= a_ch[i] * b_ch[j];
			end
		end
	end

	// Weighted sum of partials
	always_comb begin
		sum = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				sum = sum + (PW'(pp_s1[i][j]) <<< (i*CA + j*CB));
			end
		end
	end

	always_ff @(posedge clk) begin
		p_s2 <= sum;
	end

	assign p = p_s2;

endmodule

FILE: hdl/bzi_div_cell.sv
// One restoring-division cell: decides quotient bit SHIFT and passes the
// partial remainder, divisor and quotient on to the next cell.
module bzi_div_cell #(
	parameter int SHIFT = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bzi_pkg::bzi_div_ctl_t               ctl_in,
	input  logic [bzi_pkg::REM_W-1:0]           rem_in,
	input  logic [bzi_pkg::WGT_W-1:0]           den_in,
	input  logic [bzi_pkg::COORD_WIDTH-1:0]     quo_in,
	output bzi_pkg::bzi_div_ctl_t               ctl_out,
	output logic [bzi_pkg::REM_W-1:0]           rem_out,
	output logic [bzi_pkg::WGT_W-1:0]           den_out,
	output logic [bzi_pkg::COORD_WIDTH-1:0]     quo_out
);
	import bzi_pkg::*;

	logic [REM_W-1:0]       dsh;
	logic [REM_W:0]         diff;
	logic                   take;
	logic [REM_W-1:0]       rem_nx;
	logic [COORD_WIDTH-1:0] quo_nx;

	bzi_div_ctl_t           ctl_s1;
	logic [REM_W-1:0]       rem_s1;
	logic [WGT_W-1:0]       den_s1;
	logic [COORD_WIDTH-1:0] quo_s1;

	// Trial subtract of the shifted divisor
	always_comb begin
		dsh = REM_W'(den_in) << SHIFT;
		diff = {1'b0, rem_in} - {1'b0, dsh};
		take = !diff[REM_W];
		rem_nx = take ? diff[REM_W-1:0] : rem_in;
		quo_nx = quo_in;
		quo_nx[SHIFT] = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_s1 <= rem_nx;
		den_s1 <= den_in;
		quo_s1 <= quo_nx;
	end

	assign ctl_out = ctl_s1;
	assign rem_out = rem_s1;
	assign den_out = den_s1;
	assign quo_out = quo_s1;

endmodule

FILE: hdl/barycentric_z_interpolate_top.sv
// Channel   Handshake         Payload               Direction
// -------   ---------------   -------------------   ---------
// operands  start / busy      bzi_in_t (11 coords)  in
// result    done (strobe)     bzi_out_t             out
//
// One word is taken every cycle; busy stays low, the pipeline never stalls.
// The pipeline is ten arithmetic and multiplier stages, a chain of COORD_WIDTH divide
// cells (one quotient bit each) and an output register.
// done is high for exactly one cycle per word, in input order.
// Reset clears the valid bits and the divide-chain control words; data registers are not reset.
`include "barycentric_z_interpolate_top_assert.svh"

module barycentric_z_interpolate_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bzi_pkg::bzi_in_t  operands,
	output logic              done,
	output bzi_pkg::bzi_out_t result
);
	import bzi_pkg::*;

	localparam int CW = COORD_WIDTH;

	logic accept;

	// Stage 1: coordinate differences
	logic vld_s1;
	logic signed [DIFF_W-1:0] a_s1, b_s1, c_s1, dx1_s1, dy1_s1, px_s1, py_s1;
	logic signed [CW-1:0]     z_s1 [3];

	// Stages 2-3: difference products
	logic vld_s2, vld_s3;
	logic signed [CW-1:0]     z_s2 [3];
	logic signed [CW-1:0]     z_s3 [3];
	logic signed [DIFF_W-1:0] opa [6];
	logic signed [DIFF_W-1:0] opb [6];
	logic signed [PROD_W-1:0] prod_s3 [6];

	// Stage 4: det, w1, w2
	logic vld_s4;
	logic signed [WGT_W-1:0]  det_s4, w1_s4, w2_s4;
	logic signed [CW-1:0]     z_s4 [3];

	// Stage 5: w3
	logic vld_s5;
	logic signed [WGT_W-1:0]  det_s5, w1_s5, w2_s5;
	logic signed [W3_W-1:0]   w3_s5;
	logic signed [CW-1:0]     z_s5 [3];
	logic signed [W3_W-1:0]   wa [3];

	// Stages 6-7: weight times height
	logic vld_s6, vld_s7;
	logic signed [WGT_W-1:0]  det_s6, det_s7;
	logic signed [TERM_W-1:0] term_s7 [3];

	// Stage 8: numerator
	logic vld_s8, deg_s8;
	logic signed [NUM_W-1:0]  num_s8;
	logic signed [WGT_W-1:0]  det_s8;

	// Stage 9: magnitudes and sign
	logic vld_s9, deg_s9, neg_s9;
	logic [NUM_W-1:0]         nmag_s9;
	logic [WGT_W-1:0]         dmag_s9;

	// Stage 10: range check, entry to the divide chain
	logic [NUM_W-1:0]         dlim;
	logic                     ovf;
	bzi_div_ctl_t             ctl_s10;
	logic [REM_W-1:0]         rem_s10;
	logic [WGT_W-1:0]         den_s10;

	// Divide chain
	bzi_div_ctl_t             ctl_c [CW+1];
	logic [REM_W-1:0]         rem_c [CW+1];
	logic [WGT_W-1:0]         den_c [CW+1];
	logic [CW-1:0]            quo_c [CW+1];

	// Output stage
	bzi_div_ctl_t             ctl_e;
	logic [CW-1:0]            quo_e;
	logic                     fits;
	bzi_out_t                 res_nx;
	logic                     done_q;
	bzi_out_t                 result_q;

	assign busy = 1'b0;
	assign accept = start && !busy;

	// Valid bits through the arithmetic stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			ctl_s10 <= '0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			ctl_s10 <= '{vld: vld_s9, neg: neg_s9, deg: deg_s9, ovf: ovf};
			done_q <= ctl_e.vld;
		end
	end

	// Differences
	always_ff @(posedge clk) begin
		a_s1   <= DIFF_W'(operands.v2_y) - DIFF_W'(operands.v3_y);
		b_s1   <= DIFF_W'(operands.v3_x) - DIFF_W'(operands.v2_x);
		c_s1   <= DIFF_W'(operands.v3_y) - DIFF_W'(operands.v1_y);
		dx1_s1 <= DIFF_W'(operands.v1_x) - DIFF_W'(operands.v3_x);
		dy1_s1 <= DIFF_W'(operands.v1_y) - DIFF_W'(operands.v3_y);
		px_s1  <= DIFF_W'(operands.query_x) - DIFF_W'(operands.v3_x);
		py_s1  <= DIFF_W'(operands.query_y) - DIFF_W'(operands.v3_y);
		z_s1[0] <= operands.v1_z;
		z_s1[1] <= operands.v2_z;
		z_s1[2] <= operands.v3_z;
	end

	// Product pairs: det terms, w1 terms, w2 terms
	always_comb begin
		opa[0] = a_s1;   opb[0] = dx1_s1;
		opa[1] = b_s1;   opb[1] = dy1_s1;
		opa[2] = a_s1;   opb[2] = px_s1;
		opa[3] = b_s1;   opb[3] = py_s1;
		opa[4] = c_s1;   opb[4] = px_s1;
		opa[5] = dx1_s1; opb[5] = py_s1;
	end

	for (genvar k = 0; k < 6; k++) begin : g_mul_d
		bzi_mul #(
			.AW(DIFF_W),
			.BW(DIFF_W)
		) u_mul (
			.clk(clk),
			.a  (opa[k]),
			.b  (opb[k]),
			.p  (prod_s3[k])
		);
	end

	// Heights follow the multiplier latency
	always_ff @(posedge clk) begin
		z_s2 <= z_s1;
		z_s3 <= z_s2;
		z_s4 <= z_s3;
		z_s5 <= z_s4;
	end

	// Determinant and first two weights
	always_ff @(posedge clk) begin
		det_s4 <= WGT_W'(prod_s3[0]) + WGT_W'(prod_s3[1]);
		w1_s4  <= WGT_W'(prod_s3[2]) + WGT_W'(prod_s3[3]);
		w2_s4  <= WGT_W'(prod_s3[4]) + WGT_W'(prod_s3[5]);
	end

	// Third weight
	always_ff @(posedge clk) begin
		det_s5 <= det_s4;
		w1_s5  <= w1_s4;
		w2_s5  <= w2_s4;
		w3_s5  <= W3_W'(det_s4) - W3_W'(w1_s4) - W3_W'(w2_s4);
	end

	always_comb begin
		wa[0] = W3_W'(w1_s5);
		wa[1] = W3_W'(w2_s5);
		wa[2] = w3_s5;
	end

	for (genvar k = 0; k < 3; k++) begin : g_mul_z
		bzi_mul #(
			.AW(W3_W),
			.BW(CW)
		) u_mul (
			.clk(clk),
			.a  (wa[k]),
			.b  (z_s5[k]),
			.p  (term_s7[k])
		);
	end

	// Numerator and zero-determinant flag
	always_ff @(posedge clk) begin
		det_s6 <= det_s5;
		det_s7 <= det_s6;
		det_s8 <= det_s7;
		deg_s8 <= (det_s7 == '0);
		num_s8 <= NUM_W'(term_s7[0]) + NUM_W'(term_s7[1]) + NUM_W'(term_s7[2]);
	end

	// Magnitudes for the unsigned divide
	always_ff @(posedge clk) begin
		neg_s9  <= num_s8[NUM_W-1] ^ det_s8[WGT_W-1];
		deg_s9  <= deg_s8;
		nmag_s9 <= num_s8[NUM_W-1] ? NUM_W'(-num_s8) : NUM_W'(num_s8);
		dmag_s9 <= det_s8[WGT_W-1] ? WGT_W'(-det_s8) : WGT_W'(det_s8);
	end

	// Quotient needs more than CW magnitude bits when |num| >= |det| << CW
	always_comb begin
		dlim = NUM_W'(dmag_s9) << CW;
		ovf = (nmag_s9 >= dlim);
	end

	always_ff @(posedge clk) begin
		rem_s10 <= nmag_s9[REM_W-1:0];
		den_s10 <= dmag_s9;
	end

	assign ctl_c[0] = ctl_s10;
	assign rem_c[0] = rem_s10;
	assign den_c[0] = den_s10;
	assign quo_c[0] = '0;

	// Divide chain, most significant quotient bit first
	for (genvar k = 0; k < CW; k++) begin : g_div
		bzi_div_cell #(
			.SHIFT(CW - 1 - k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_in (ctl_c[k]),
			.rem_in (rem_c[k]),
			.den_in (den_c[k]),
			.quo_in (quo_c[k]),
			.ctl_out(ctl_c[k+1]),
			.rem_out(rem_c[k+1]),
			.den_out(den_c[k+1]),
			.quo_out(quo_c[k+1])
		);
	end

	assign ctl_e = ctl_c[CW];
	assign quo_e = quo_c[CW];

	// Sign, saturation and degenerate handling
	always_comb begin
		fits = !ctl_e.ovf && (!quo_e[CW-1] || (ctl_e.neg && quo_e[CW-2:0] == '0));
		res_nx.degenerate = ctl_e.deg;
		res_nx.saturated = !ctl_e.deg && !fits;
		if (ctl_e.deg) begin
			res_nx.height = '0;
		end else if (!fits) begin
			res_nx.height = ctl_e.neg ? H_MIN : H_MAX;
		end else begin
			res_nx.height = ctl_e.neg ? CW'(-quo_e) : quo_e;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_nx;
	end

	assign done = done_q;
	assign result = result_q;

	// Checks
	`BZI_ASSERT_NEXT(a_deg_out, clk, arst_n, ctl_e.vld && ctl_e.deg,
		done && result.degenerate && !result.saturated && result.height == '0,
		"degenerate word did not give a zero height")
	`BZI_ASSERT_NEXT(a_ovf_sat, clk, arst_n, ctl_e.vld && !ctl_e.deg && ctl_e.ovf,
		done && result.saturated, "out-of-range quotient not saturated")
	`BZI_ASSERT_SAME(a_sat_rail, clk, arst_n, done && result.saturated,
		result.height == H_MAX || result.height == H_MIN, "saturated height not at a rail")
	`BZI_ASSERT_SAME(a_rem_bound, clk, arst_n, ctl_e.vld && !ctl_e.deg && !ctl_e.ovf,
		rem_c[CW] < REM_W'(den_c[CW]), "final remainder not below divisor")

endmodule
